// ===== sv/fic_pkg.sv =====
package fic_pkg;

  localparam int TransformSize = 1024;
  localparam int HalfSize      = TransformSize / 2;
  localparam int AddrBits      = $clog2(HalfSize);
  localparam int CountBits     = AddrBits + 1;
  localparam int PAddrBits     = $clog2(TransformSize);
  localparam int CoeffBits     = 16;
  localparam int ProdBits      = 40;
  localparam int MulBits       = 2 * CoeffBits;
  localparam int AccBits       = ProdBits + 1;

  typedef enum logic [1:0] {
    FUNC_LOAD_A  = 2'd0,
    FUNC_LOAD_B  = 2'd1,
    FUNC_COMPUTE = 2'd2,
    FUNC_READ    = 2'd3
  } func_t;

  // control that travels with one term through the MAC pipeline
  typedef struct packed {
    logic                 valid;
    logic                 zero;
    logic                 last;
    logic [PAddrBits-1:0] k;
  } mac_ctl_t;

endpackage

// ===== sv/fic_in_if.sv =====
interface fic_in_if;
  import fic_pkg::*;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  func;
  logic signed [CoeffBits-1:0] coeff;
  modport source (output valid, func, coeff, input ready);
  modport sink (input valid, func, coeff, output ready);
endinterface

// ===== sv/fic_out_if.sv =====
interface fic_out_if;
  import fic_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [ProdBits-1:0] product;
  logic                       last;
  logic                       overflow;
  modport source (output valid, product, last, overflow, input ready);
  modport sink (input valid, product, last, overflow, output ready);
endinterface

// ===== sv/fic_mac.sv =====
module fic_mac (
  input  logic                               clk,
  input  logic                               rst,
  input  fic_pkg::mac_ctl_t                  ctl,
  input  logic signed [fic_pkg::CoeffBits-1:0] a,
  input  logic signed [fic_pkg::CoeffBits-1:0] b,
  output logic                               wr_valid,
  output logic [fic_pkg::PAddrBits-1:0]      wr_addr,
  output logic signed [fic_pkg::ProdBits-1:0] wr_data
);
  import fic_pkg::*;

  localparam logic signed [AccBits-1:0] PMax =
    AccBits'({1'b0, {(ProdBits-1){1'b1}}});

  mac_ctl_t                  ctl_m;
  logic signed [MulBits-1:0] a_w;
  logic signed [MulBits-1:0] b_w;
  logic signed [MulBits-1:0] mul;
  logic signed [AccBits-1:0] acc;
  logic signed [AccBits-1:0] acc_next;

  // sign-extend the operands to the full product width
  assign a_w      = a;
  assign b_w      = b;
  assign acc_next = acc + AccBits'(mul);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_m.valid <= 1'b0;
      wr_valid    <= 1'b0;
      acc         <= '0;
    end else begin
      ctl_m <= ctl;
      mul   <= ctl.zero ? '0 : a_w * b_w;
      wr_valid <= ctl_m.valid && ctl_m.last;
      if (ctl_m.valid) begin
        if (ctl_m.last) begin
          acc     <= '0;
          wr_addr <= ctl_m.k;
          // only the top bound is reachable
          wr_data <= (acc_next > PMax) ? PMax[ProdBits-1:0] : acc_next[ProdBits-1:0];
        end else begin
          acc <= acc_next;
        end
      end
    end
  end
endmodule

// ===== sv/fft_integer_convolution.sv =====
// Polynomial multiplier for two signed 16-bit coefficient sequences.
// Channel req (sink) carries transactions with func and coeff:
//   load first operand, load second operand, compute, read next result.
// Channel rsp (source) returns one transaction per read that still has a
// coefficient left: product (40-bit), last on the top coefficient, and
// overflow when a load before that compute was dropped (operand held 512).
// A read's coefficient is registered from the product memory and then
// moved into the output register that drives rsp.
// A compute walks the exact convolution through one multiply-accumulate
// unit fed from the two operand memories: per product coefficient k a
// setup state finds the overlapping terms, and the run state then issues
// one term per cycle; a drain state lets the MAC pipeline empty at the end.
// The single MAC and the single read port on each operand memory set
// how long a compute takes.
// Reset clears counts, read pointer, product length and flags; memories
// keep their contents. When rsp stalls, the result holds in the output
// register and further reads wait; loads and computes still go through.
module fft_integer_convolution (
  input logic clk,
  input logic rst,
  fic_in_if.sink  req,
  fic_out_if.source rsp
);
  import fic_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SETUP, S_RUN, S_DRAIN} state_t;

  logic signed [CoeffBits-1:0] mem_a [HalfSize];
  logic signed [CoeffBits-1:0] mem_b [HalfSize];
  logic signed [ProdBits-1:0]  mem_p [TransformSize];

  state_t               state;
  logic [CountBits-1:0] cnt_a, cnt_b, na, nb;
  logic                 dropped, ovf;
  logic [PAddrBits-1:0] len, rp, k;
  logic [CountBits-1:0] i, hi;
  logic [1:0]           drain;
  logic                 pend, pend_last;
  logic                 empty;

  logic signed [CoeffBits-1:0] a_q, b_q;
  logic signed [ProdBits-1:0]  p_q;
  mac_ctl_t             ctl;
  logic                 wr_valid;
  logic [PAddrBits-1:0] wr_addr;
  logic signed [ProdBits-1:0] wr_data;

  logic                 acc_in;
  func_t                func;
  logic [PAddrBits:0]   k_ext, lo_w, hi_w, nb_m1;
  logic [AddrBits-1:0]  b_addr;
  logic [CountBits:0]   tot;

  assign func   = func_t'(req.func);
  assign req.ready = (state == S_IDLE) && !pend && !(func == FUNC_READ && rsp.valid);
  assign acc_in = req.valid && req.ready;
  assign empty  = (na == '0) || (nb == '0);
  // both operands full gives 1024, one bit past a count
  assign tot    = {1'b0, cnt_a} + {1'b0, cnt_b};

  // term range for coefficient k: lo = max(0, k-nb+1), hi = min(k, na-1)
  assign k_ext = {1'b0, k};
  assign nb_m1 = (PAddrBits+1)'(nb) - 1'b1;
  assign lo_w  = (k_ext >= nb_m1) ? k_ext - nb_m1 : '0;
  assign hi_w  = (k_ext < (PAddrBits+1)'(na)) ? k_ext : (PAddrBits+1)'(na) - 1'b1;
  assign b_addr = AddrBits'(k - PAddrBits'(i));

  always_ff @(posedge clk) begin
    if (acc_in && func == FUNC_LOAD_A && cnt_a < CountBits'(HalfSize))
      mem_a[cnt_a[AddrBits-1:0]] <= req.coeff;
    if (acc_in && func == FUNC_LOAD_B && cnt_b < CountBits'(HalfSize))
      mem_b[cnt_b[AddrBits-1:0]] <= req.coeff;
    a_q <= mem_a[i[AddrBits-1:0]];
    b_q <= mem_b[b_addr];
    if (wr_valid)
      mem_p[wr_addr] <= wr_data;
    p_q <= mem_p[rp];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt_a     <= '0;
      cnt_b     <= '0;
      dropped   <= 1'b0;
      ovf       <= 1'b0;
      len       <= '0;
      rp        <= '0;
      pend      <= 1'b0;
      rsp.valid <= 1'b0;
      ctl.valid <= 1'b0;
    end else begin
      ctl.valid <= 1'b0;
      if (rsp.valid && rsp.ready)
        rsp.valid <= 1'b0;
      // move the read data into the output register
      if (pend) begin
        pend         <= 1'b0;
        rsp.valid    <= 1'b1;
        rsp.product  <= p_q;
        rsp.last     <= pend_last;
        rsp.overflow <= ovf;
      end
      case (state)
        S_IDLE: begin
          if (acc_in) begin
            case (func)
              FUNC_LOAD_A: begin
                if (cnt_a < CountBits'(HalfSize)) cnt_a <= cnt_a + 1'b1;
                else dropped <= 1'b1;
              end
              FUNC_LOAD_B: begin
                if (cnt_b < CountBits'(HalfSize)) cnt_b <= cnt_b + 1'b1;
                else dropped <= 1'b1;
              end
              FUNC_COMPUTE: begin
                na      <= cnt_a;
                nb      <= cnt_b;
                len     <= (tot == '0) ? '0 : PAddrBits'(tot - 1'b1);
                ovf     <= dropped;
                cnt_a   <= '0;
                cnt_b   <= '0;
                dropped <= 1'b0;
                rp      <= '0;
                k       <= '0;
                if (tot > (CountBits+1)'(1)) state <= S_SETUP;
              end
              FUNC_READ: begin
                if (rp < len) begin
                  pend      <= 1'b1;
                  pend_last <= (rp + 1'b1 == len);
                  rp        <= rp + 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        S_SETUP: begin
          i     <= empty ? '0 : CountBits'(lo_w);
          hi    <= empty ? '0 : CountBits'(hi_w);
          state <= S_RUN;
        end
        S_RUN: begin
          ctl.valid <= 1'b1;
          ctl.zero  <= empty;
          ctl.last  <= (i == hi);
          ctl.k     <= k;
          if (i == hi) begin
            if (k + 1'b1 == len) begin
              drain <= '1;
              state <= S_DRAIN;
            end else begin
              k     <= k + 1'b1;
              state <= S_SETUP;
            end
          end else begin
            i <= i + 1'b1;
          end
        end
        S_DRAIN: begin
          // hold until the last coefficient is written back
          if (drain == '0) state <= S_IDLE;
          else drain <= drain - 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  fic_mac u_mac (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .a        (a_q),
    .b        (b_q),
    .wr_valid (wr_valid),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data)
  );

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt_a <= CountBits'(HalfSize) && cnt_b <= CountBits'(HalfSize))
    else $error("operand count above capacity");
  a_wr_idle: assert property (@(posedge clk) disable iff (rst)
    wr_valid |-> state != S_IDLE)
    else $error("product write-back outside compute");
  a_rp_len: assert property (@(posedge clk) disable iff (rst)
    rp <= len)
    else $error("read pointer past product length");
  a_pend: assert property (@(posedge clk) disable iff (rst)
    pend |=> rsp.valid)
    else $error("pending read lost");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import fic_pkg::*;

  localparam int CycleLimit = 3_000_000;
  localparam int DrainCycles = 16;
  localparam longint ProdMax = (64'sd1 <<< (ProdBits - 1)) - 1;
  localparam longint ProdMin = -(64'sd1 <<< (ProdBits - 1));

  logic clk;
  logic rst;

  fic_in_if  req ();
  fic_out_if rsp ();

  fft_integer_convolution i_dut (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source)
  );

  int unsigned error_count;
  int unsigned cycle_count;
  bit          no_idle;

  // print one mismatch line and count it
  task automatic report(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  typedef struct {
    logic signed [ProdBits-1:0] product;
    logic                       last;
    logic                       overflow;
  } coeff_result_t;

  // Scoreboard: tracks the multiplier state and queues the coefficients
  // that reads are expected to return.
  class product_board;
    longint        first_ops[$];
    longint        second_ops[$];
    longint        products[$];
    bit            drop_seen;
    bit            latched_drop;
    int            next_read;
    coeff_result_t pending[$];

    function void note_input(input logic [1:0] fn, input logic signed [CoeffBits-1:0] c);
      longint acc;
      int     plen;
      case (func_t'(fn))
        FUNC_LOAD_A: begin
          if (first_ops.size() >= HalfSize) drop_seen = 1;
          else first_ops.push_back(longint'(c));
        end
        FUNC_LOAD_B: begin
          if (second_ops.size() >= HalfSize) drop_seen = 1;
          else second_ops.push_back(longint'(c));
        end
        FUNC_COMPUTE: begin
          plen = first_ops.size() + second_ops.size();
          plen = (plen == 0) ? 0 : plen - 1;
          products.delete();
          for (int k = 0; k < plen; k++) begin
            acc = 0;
            for (int i = 0; i < first_ops.size(); i++)
              if (i <= k && k - i < second_ops.size())
                acc += first_ops[i] * second_ops[k - i];
            if (acc > ProdMax) acc = ProdMax;
            if (acc < ProdMin) acc = ProdMin;
            products.push_back(acc);
          end
          latched_drop = drop_seen;
          drop_seen = 0;
          first_ops.delete();
          second_ops.delete();
          next_read = 0;
        end
        default: begin
          if (next_read < products.size()) begin
            pending.push_back('{products[next_read][ProdBits-1:0],
                                next_read + 1 == products.size(), latched_drop});
            next_read++;
          end
        end
      endcase
    endfunction

    task check_result(input logic signed [ProdBits-1:0] p, input logic l,
                      input logic o);
      coeff_result_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result product=%0d", p));
        return;
      end
      e = pending.pop_front();
      if (p !== e.product) report($sformatf("product %0d, want %0d", p, e.product));
      if (l !== e.last) report($sformatf("last %0b, want %0b", l, e.last));
      if (o !== e.overflow) report($sformatf("overflow %0b, want %0b", o, e.overflow));
    endtask
  endclass

  product_board board = new();

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watch both channels at each edge; the driver only changes inputs
  // through nonblocking assignments, so these are the settled values.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && req.valid && req.ready) board.note_input(req.func, req.coeff);
    if (!rst && rsp.valid && rsp.ready) board.check_result(rsp.product, rsp.last, rsp.overflow);
  end

  // hard stop in case the block hangs
  always @(posedge clk) begin
    if (cycle_count >= CycleLimit) begin
      $display("[fft_integer_convolution] ERROR");
      $finish;
    end
  end

  // Random backpressure on the result side, off during the quiet stretch.
  always @(posedge clk) begin
    if (rst) rsp.ready <= 1'b0;
    else rsp.ready <= no_idle || ($urandom_range(99) >= 38);
  end

  // Send one transaction; hold valid until it is accepted, then maybe idle.
  task automatic send(input func_t fn, input logic signed [CoeffBits-1:0] c);
    int gap;
    req.valid <= 1'b1;
    req.func  <= fn;
    req.coeff <= c;
    do @(posedge clk); while (!req.ready);
    if (!no_idle && $urandom_range(99) < 38) begin
      req.valid <= 1'b0;
      req.func  <= func_t'($urandom_range(3));
      req.coeff <= CoeffBits'($urandom);
      gap = $urandom_range(1, 4);
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off until every queued coefficient has come back.
  task automatic wait_drained();
    req.valid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  // one well-formed multiply: load, compute, read everything plus extras
  task automatic run_round(input int na, input int nb, input int extra, input bit noisy);
    int total;
    for (int i = 0; i < na || i < nb; i++) begin
      if (i < na) send(FUNC_LOAD_A, CoeffBits'($urandom));
      if (i < nb) send(FUNC_LOAD_B, CoeffBits'($urandom));
      if (noisy && $urandom_range(9) == 0) send(FUNC_READ, CoeffBits'($urandom));
    end
    if ($urandom_range(3) == 0) wait_drained();
    send(FUNC_COMPUTE, CoeffBits'($urandom));
    total = (na + nb == 0) ? 0 : na + nb - 1;
    if (total > HalfSize * 2) total = HalfSize * 2;
    for (int i = 0; i < total + extra; i++) send(FUNC_READ, CoeffBits'($urandom));
  endtask

  int sent;
  int na;
  int nb;

  initial begin
    rst         <= 1'b1;
    req.valid   <= 1'b0;
    req.func    <= FUNC_LOAD_A;
    req.coeff   <= '0;
    error_count = 0;
    cycle_count = 0;
    no_idle     = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // read before any compute, then an empty compute
    send(FUNC_READ, 16'sh7fff);
    send(FUNC_COMPUTE, '0);
    send(FUNC_READ, '0);
    // one operand empty: zeros only
    send(FUNC_LOAD_A, 16'sh0005);
    send(FUNC_LOAD_A, -16'sd3);
    send(FUNC_LOAD_A, 16'sh7fff);
    send(FUNC_COMPUTE, '0);
    repeat (3) send(FUNC_READ, '0);
    // field extremes on both operands
    send(FUNC_LOAD_A, 16'sh7fff);
    send(FUNC_LOAD_A, 16'sh8000);
    send(FUNC_LOAD_B, 16'sh8000);
    send(FUNC_LOAD_B, 16'sh7fff);
    send(FUNC_LOAD_B, 16'shffff);
    wait_drained();
    send(FUNC_COMPUTE, '0);
    repeat (5) send(FUNC_READ, '0);

    // full operands of the most negative value: the middle coefficient
    // saturates, and the extra load on each side is dropped
    no_idle = 1;
    for (int i = 0; i <= HalfSize; i++) begin
      send(FUNC_LOAD_A, 16'sh8000);
      send(FUNC_LOAD_B, 16'sh8000);
    end
    no_idle = 0;
    send(FUNC_COMPUTE, '0);
    for (int i = 0; i < 2 * HalfSize; i++) send(FUNC_READ, '0);
    wait_drained();

    // random rounds, mostly short operands; a quiet stretch in the middle
    sent = 0;
    for (int r = 0; sent < 700; r++) begin
      no_idle = (r >= 10 && r < 18);
      if ($urandom_range(9) == 0) begin
        na = $urandom_range(0, 40);
        nb = $urandom_range(0, 40);
      end else begin
        na = $urandom_range(0, 8);
        nb = $urandom_range(0, 8);
      end
      if ($urandom_range(7) == 0) begin
        // noise: random operations in any order
        for (int i = 0; i < 12; i++)
          send(func_t'($urandom_range(3)), CoeffBits'($urandom));
        sent += 12;
      end else begin
        run_round(na, nb, $urandom_range(0, 2), $urandom_range(3) == 0);
        sent += 2 * (na + nb) + 1;
      end
    end
    no_idle = 0;

    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0 && board.pending.size() == 0) begin
      $display("[fft_integer_convolution] OK");
    end else begin
      $display("[fft_integer_convolution] ERROR");
    end
    $finish;
  end

endmodule
